FILE: rtl/c8x_pkg.sv
// shared constants, codes and interface structs of the chip-8 subset executor
package c8x_pkg;

  // storage sizes
  localparam int MEMORY_BYTES = 4096;
  localparam int SCREEN_ROWS  = 32;
  localparam int ROW_BYTES    = 8;
  localparam int FRAME_BYTES  = SCREEN_ROWS * ROW_BYTES;
  localparam int MEM_AW       = $clog2(MEMORY_BYTES);
  localparam int ROW_W        = $clog2(SCREEN_ROWS);
  localparam int FR_AW        = ROW_W + 3;

  // stream widths
  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  // item kinds carried on in_tuser
  localparam logic [1:0] KIND_WR   = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_RD   = 2'd2;

  // instruction families, top nibble
  localparam logic [3:0] OP_SYS = 4'h0;
  localparam logic [3:0] OP_JP  = 4'h1;
  localparam logic [3:0] OP_LD  = 4'h6;
  localparam logic [3:0] OP_ADD = 4'h7;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_DRW = 4'hD;

  localparam logic [15:0] CLS_WORD = 16'h00E0;
  localparam logic [11:0] PC_RESET = 12'd512;
  localparam logic [11:0] PC_STEP  = 12'd2;
  localparam logic [3:0]  FLAG_REG = 4'hF;

  // shared adder / subtractor
  typedef struct packed {
    logic        sub;
    logic [11:0] a;
    logic [11:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        carry;  // a >= b on subtract
    logic [11:0] res;
  } alu_res_t;

  // main memory port
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  // frame store port
  typedef struct packed {
    logic             clr;
    logic             wr_en;
    logic [FR_AW-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [FR_AW-1:0] rd_addr;
  } frm_req_t;

  // result word, first field highest
  typedef struct packed {
    logic        unsupported;
    logic [7:0]  frame_byte;
    logic        collision;
    logic [11:0] index_out;
    logic [11:0] program_counter_out;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

FILE: rtl/chip8_subset_executor_unit.sv
// top level of the chip-8 subset executor: sequencer, register file and stream ports
//
// Each input word is one of three things, chosen by in_tuser: a byte write into the
// 4 KB main memory, one 16-bit instruction to execute, or a byte read from the 64x32
// frame store (8 bytes per row, msb leftmost). Exactly one result word comes back per
// input word, carrying the program counter and index register after the item, the
// collision flag of a draw, the frame byte of a read and an unsupported-instruction flag.
// Supported: 00E0 clear, 1NNN jump, 6XNN set, 7XNN add (8-bit wrap, VF untouched),
// ANNN set index and DXYN sprite XOR with wrap on both axes and VF = collision; any other
// word only advances the counter by 2 and raises unsupported. The block handles one word
// at a time under a small sequencer that drives a single shared 12-bit adder/subtractor;
// in_tready is high only while the sequencer is idle, and a finished result waits in the
// output register so the next word can be taken while it is still pending.
// Steps per word: a memory write or an unused kind goes straight to the result; a frame
// read waits for the registered frame byte; an instruction goes through execute. A draw
// reduces VY mod the row count by repeated subtraction, then for each sprite row fetches
// the sprite byte, reads and rewrites the left frame byte and, when the x position is not
// byte aligned, reads and rewrites the second frame byte, and at the end writes VF. The
// per-row steps are set by the single memory read port and the read-modify-write of the
// frame store through its one read and one write port. The frame store needs no clearing
// pass: per-byte valid bits are cleared all together by reset and by 00E0.
module chip8_subset_executor_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [c8x_pkg::IN_W-1:0] in_tdata,   // address[11:0], data[19:12], instruction[35:20]
  input  logic [1:0]               in_tuser,   // item kind[1:0]
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [c8x_pkg::OUT_W-1:0] out_tdata  // program_counter_out[11:0], index_out[23:12],
                                               // collision[24], frame_byte[32:25],
                                               // unsupported[33]
);
  import c8x_pkg::*;

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_EXEC   = 13'b0000000000100,
    S_FWAIT  = 13'b0000000001000,
    S_DVY    = 13'b0000000010000,
    S_DYMOD  = 13'b0000000100000,
    S_DFETCH = 13'b0000001000000,
    S_DSPR   = 13'b0000010000000,
    S_DLRD   = 13'b0000100000000,
    S_DRRD   = 13'b0001000000000,
    S_DNEXT  = 13'b0010000000000,
    S_DEND   = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  localparam logic [12:0]      MEM_LIMIT = 13'(MEMORY_BYTES);
  localparam logic [11:0]      FR_LIMIT  = 12'(FRAME_BYTES);
  localparam logic [11:0]      ROWS_12   = 12'(SCREEN_ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [ROW_W:0]   ROWS_CMP  = (ROW_W + 1)'(SCREEN_ROWS);

  state_t      state_r, state_nxt;

  // latched item
  logic [1:0]  op_r, op_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [15:0] word_r, word_nxt;

  // architectural state
  logic [11:0] pc_r, pc_nxt;
  logic [11:0] idx_r, idx_nxt;
  logic [7:0]  rf_r [16];
  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [7:0]  rf_wd;

  // draw working registers
  logic [5:0]       x_r, x_nxt;
  logic [7:0]       ymod_r, ymod_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [3:0]       i_r, i_nxt;
  logic             hit_r, hit_nxt;
  logic             oob_r, oob_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [7:0]       right_r, right_nxt;

  // result under construction
  logic        rng_r, rng_nxt;
  logic [7:0]  fb_r, fb_nxt;
  logic        bad_r, bad_nxt;
  logic        coll_r, coll_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r, out_res_nxt;

  // shared units
  alu_req_t    alu_req;
  alu_res_t    alu_res;
  mem_req_t    mem_req;
  logic [7:0]  mem_q;
  frm_req_t    frm_req;
  logic [7:0]  frm_q;

  // instruction fields
  logic [3:0]  top_nib, xr, yr, nib;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [2:0]  col;
  logic [2:0]  shift;
  logic [7:0]  sprite;
  logic [15:0] spr_wide;
  logic [7:0]  old_l;

  assign top_nib = word_r[15:12];
  assign xr      = word_r[11:8];
  assign yr      = word_r[7:4];
  assign nib     = word_r[3:0];
  assign nn      = word_r[7:0];
  assign nnn     = word_r[11:0];
  assign col     = x_r[5:3];
  assign shift   = x_r[2:0];

  // sprite byte split across two frame bytes by the pixel offset
  assign sprite   = oob_r ? 8'h00 : mem_q;
  assign spr_wide = {sprite, 8'h00} >> shift;
  assign old_l    = frm_q;

  c8x_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  c8x_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_q)
  );

  c8x_frame u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (frm_req),
    .rd_data (frm_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - RES_W){1'b0}}, out_res_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    word_nxt  = word_r;
    pc_nxt    = pc_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    ymod_nxt  = ymod_r;
    row_nxt   = row_r;
    i_nxt     = i_r;
    hit_nxt   = hit_r;
    oob_nxt   = oob_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    rng_nxt   = rng_r;
    fb_nxt    = fb_r;
    bad_nxt   = bad_r;
    coll_nxt  = coll_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    rf_we   = 1'b0;
    rf_wa   = xr;
    rf_wd   = nn;
    alu_req = '0;
    mem_req = '0;
    frm_req = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          addr_nxt  = in_tdata[11:0];
          data_nxt  = in_tdata[19:12];
          word_nxt  = in_tdata[35:20];
          fb_nxt    = 8'h00;
          bad_nxt   = 1'b0;
          coll_nxt  = 1'b0;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        case (op_r)
          KIND_WR: begin
            mem_req.wr_en   = ({1'b0, addr_r} < MEM_LIMIT);
            mem_req.addr    = addr_r[MEM_AW-1:0];
            mem_req.wr_data = data_r;
            state_nxt       = S_DONE;
          end
          KIND_RD: begin
            rng_nxt         = (addr_r < FR_LIMIT);
            frm_req.rd_en   = (addr_r < FR_LIMIT);
            frm_req.rd_addr = addr_r[FR_AW-1:0];
            state_nxt       = S_FWAIT;
          end
          KIND_EXEC: begin
            alu_req.a = pc_r;
            alu_req.b = PC_STEP;
            pc_nxt    = alu_res.res;
            state_nxt = S_EXEC;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_FWAIT: begin
        fb_nxt    = rng_r ? frm_q : 8'h00;
        state_nxt = S_DONE;
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (top_nib)
          OP_SYS: begin
            if (word_r == CLS_WORD) begin
              frm_req.clr = 1'b1;
            end else begin
              bad_nxt = 1'b1;
            end
          end
          OP_JP: begin
            pc_nxt = nnn;
          end
          OP_LD: begin
            rf_we = 1'b1;
          end
          OP_ADD: begin
            alu_req.a = {4'd0, rf_r[xr]};
            alu_req.b = {4'd0, nn};
            rf_we     = 1'b1;
            rf_wd     = alu_res.res[7:0];
          end
          OP_LDI: begin
            idx_nxt = nnn;
          end
          OP_DRW: begin
            x_nxt     = rf_r[xr][5:0];
            state_nxt = S_DVY;
          end
          default: begin
            bad_nxt = 1'b1;
          end
        endcase
      end

      S_DVY: begin
        ymod_nxt  = rf_r[yr];
        i_nxt     = 4'd0;
        hit_nxt   = 1'b0;
        state_nxt = (nib == 4'd0) ? S_DEND : S_DYMOD;
      end

      // reduce vy to a row by repeated subtraction
      S_DYMOD: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {4'd0, ymod_r};
        alu_req.b   = ROWS_12;
        if (alu_res.carry) begin
          ymod_nxt = alu_res.res[7:0];
        end else begin
          row_nxt   = ymod_r[ROW_W-1:0];
          state_nxt = S_DFETCH;
        end
      end

      // sprite byte address i + I, wrapped at 12 bits
      S_DFETCH: begin
        alu_req.a     = idx_r;
        alu_req.b     = {8'd0, i_r};
        oob_nxt       = !({1'b0, alu_res.res} < MEM_LIMIT);
        mem_req.rd_en = ({1'b0, alu_res.res} < MEM_LIMIT);
        mem_req.addr  = alu_res.res[MEM_AW-1:0];
        state_nxt     = S_DSPR;
      end

      S_DSPR: begin
        left_nxt        = spr_wide[15:8];
        right_nxt       = spr_wide[7:0];
        frm_req.rd_en   = 1'b1;
        frm_req.rd_addr = {row_r, col};
        state_nxt       = S_DLRD;
      end

      // left byte read-modify-write, then fetch the neighbor column when x is not byte aligned
      S_DLRD: begin
        frm_req.wr_en   = 1'b1;
        frm_req.wr_addr = {row_r, col};
        frm_req.wr_data = old_l ^ left_r;
        hit_nxt         = hit_r | (|(old_l & left_r));
        if (shift != 3'd0) begin
          frm_req.rd_en   = 1'b1;
          frm_req.rd_addr = {row_r, col + 3'd1};
          state_nxt       = S_DRRD;
        end else begin
          state_nxt = S_DNEXT;
        end
      end

      S_DRRD: begin
        frm_req.wr_en   = 1'b1;
        frm_req.wr_addr = {row_r, col + 3'd1};
        frm_req.wr_data = old_l ^ right_r;
        hit_nxt         = hit_r | (|(old_l & right_r));
        state_nxt       = S_DNEXT;
      end

      S_DNEXT: begin
        i_nxt     = i_r + 4'd1;
        row_nxt   = (row_r == ROW_LAST) ? '0 : row_r + ROW_W'(1);
        state_nxt = (i_r + 4'd1 == nib) ? S_DEND : S_DFETCH;
      end

      S_DEND: begin
        rf_we     = 1'b1;
        rf_wa     = FLAG_REG;
        rf_wd     = {7'd0, hit_r};
        coll_nxt  = hit_r;
        state_nxt = S_DONE;
      end

      // park the result once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt                   = 1'b1;
          out_res_nxt.program_counter_out = pc_r;
          out_res_nxt.index_out           = idx_r;
          out_res_nxt.collision           = coll_r;
          out_res_nxt.frame_byte          = fb_r;
          out_res_nxt.unsupported         = bad_r;
          state_nxt                       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= PC_RESET;
      idx_r       <= 12'd0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 16; k++) begin
        rf_r[k] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_r[rf_wa] <= rf_wd;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    addr_r    <= addr_nxt;
    data_r    <= data_nxt;
    word_r    <= word_nxt;
    x_r       <= x_nxt;
    ymod_r    <= ymod_nxt;
    row_r     <= row_nxt;
    i_r       <= i_nxt;
    hit_r     <= hit_nxt;
    oob_r     <= oob_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    rng_r     <= rng_nxt;
    fb_r      <= fb_nxt;
    bad_r     <= bad_nxt;
    coll_r    <= coll_nxt;
    out_res_r <= out_res_nxt;
  end

  // a taken word closes the input until its result is parked
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in flight");

  // frame writes only come from the draw read-modify-write steps
  a_frame_wr_src: assert property (@(posedge clk) disable iff (!rst_n)
    frm_req.wr_en |-> (state_r == S_DLRD || state_r == S_DRRD))
    else $error("frame write outside a draw");

  // wrapped draw row stays inside the frame
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSPR || state_r == S_DLRD || state_r == S_DRRD)
      |-> ({1'b0, row_r} < ROWS_CMP))
    else $error("draw row out of range");

  // a draw never also reports an unsupported word
  a_coll_vs_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.collision && out_res_r.unsupported))
    else $error("collision and unsupported both set");

endmodule

FILE: rtl/c8x_alu.sv
// shared 12-bit adder and subtractor
module c8x_alu (
  input  c8x_pkg::alu_req_t req,
  output c8x_pkg::alu_res_t res
);
  import c8x_pkg::*;

  logic [12:0] sum;

  // subtract as a + ~b + 1, carry out means no borrow
  assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {12'd0, req.sub};
  assign res.res   = sum[11:0];
  assign res.carry = sum[12];

endmodule

FILE: rtl/c8x_mem.sv
// main program and sprite memory, one port, registered read
module c8x_mem (
  input  logic              clk,
  input  c8x_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);
  import c8x_pkg::*;

  logic [7:0] mem_r [MEMORY_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/c8x_frame.sv
// frame store with per-byte valid bits, unwritten bytes read as zero
module c8x_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  c8x_pkg::frm_req_t req,
  output logic [7:0]        rd_data
);
  import c8x_pkg::*;

  logic [7:0]             mem_r [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] vld_r;
  logic [7:0]             q_r;
  logic                   q_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r     <= mem_r[req.rd_addr];
      q_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = q_vld_r ? q_r : 8'h00;

endmodule
